// ===== hdl/rvdec_pkg.sv =====
// Shared types and constants for the RV32IM instruction decoder.
// Used by every stage module and by the top level; depends on nothing.
package rvdec_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned REG_W   = 5;
  localparam int unsigned TDATA_W = 80;
  localparam int unsigned TUSER_W = 13;

  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_MISC   = 7'h0F;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;
  localparam logic [6:0] SRX_MASK   = 7'h5F;
  localparam logic [6:0] F7_BASE    = 7'h00;
  localparam logic [6:0] F7_ALT     = 7'h20;
  localparam logic [6:0] F7_MULDIV  = 7'h01;

  typedef enum logic [3:0] {
    GRP_BAD, GRP_LUI, GRP_AUIPC, GRP_JAL, GRP_JALR, GRP_BRANCH, GRP_LOAD,
    GRP_STORE, GRP_OPIMM, GRP_OP, GRP_MISC, GRP_SYSTEM
  } grp_t;

  typedef enum logic [5:0] {
    OP_INVALID = 6'd0,
    OP_LUI     = 6'd1,  OP_AUIPC  = 6'd2,  OP_JAL    = 6'd3,  OP_JALR   = 6'd4,
    OP_BEQ     = 6'd5,  OP_BNE    = 6'd6,  OP_BLT    = 6'd7,  OP_BGE    = 6'd8,
    OP_BLTU    = 6'd9,  OP_BGEU   = 6'd10, OP_LB     = 6'd11, OP_LH     = 6'd12,
    OP_LW      = 6'd13, OP_LBU    = 6'd14, OP_LHU    = 6'd15, OP_SB     = 6'd16,
    OP_SH      = 6'd17, OP_SW     = 6'd18, OP_ADD    = 6'd19, OP_SUB    = 6'd20,
    OP_SLL     = 6'd21, OP_SLT    = 6'd22, OP_SLTU   = 6'd23, OP_XOR    = 6'd24,
    OP_SRL     = 6'd25, OP_SRA    = 6'd26, OP_OR     = 6'd27, OP_AND    = 6'd28,
    OP_MUL     = 6'd29, OP_MULH   = 6'd30, OP_MULHSU = 6'd31, OP_MULHU  = 6'd32,
    OP_DIV     = 6'd33, OP_DIVU   = 6'd34, OP_REM    = 6'd35, OP_REMU   = 6'd36,
    OP_FENCE   = 6'd37, OP_FENCE_I = 6'd38, OP_ECALL = 6'd39, OP_EBREAK = 6'd40
  } op_t;

  typedef enum logic [2:0] {
    CLS_ALU, CLS_BRANCH, CLS_LOAD, CLS_STORE, CLS_MUL, CLS_DIV, CLS_NOP, CLS_TRAP
  } cls_t;

  typedef enum logic [2:0] {
    IMM_NONE, IMM_I, IMM_S, IMM_B, IMM_U, IMM_J, IMM_SH
  } imm_fmt_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    grp_t              grp;
  } s1_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    op_t               op;
    cls_t              cls;
    imm_fmt_t          fmt;
    logic              use_d;
    logic              use_s1;
    logic              use_s2;
    logic              br;
    logic              ld;
    logic              st;
    logic              wr;
  } s2_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] imm;
    logic [REG_W-1:0]  rs2;
    logic [REG_W-1:0]  rs1;
    logic [REG_W-1:0]  rd;
    op_t               op;
    cls_t              cls;
    logic              br;
    logic              ld;
    logic              st;
    logic              wr;
  } res_t;

endpackage

// ===== hdl/rv32im_instruction_decoder.sv =====
// Top level of the RV32IM instruction decoder: three register stages and the stream ports.
// Depends on rvdec_pkg, rvdec_fields, rvdec_ops and rvdec_pack.

// The decoder takes one 32-bit instruction word per beat and returns one decoded
// result per beat once the word has passed all three register stages. It accepts
// a new word in every cycle unless the full pipeline is stalled by the result side;
// the three register stages (opcode group, operation resolution, immediate and field
// assembly) each hold one beat, so up to three words are in flight. Unrecognized
// encodings come out as the invalid operation in trap class with all register
// fields, the immediate and the flags zero.
module rv32im_instruction_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [31:0] instr_word
  input  logic [rvdec_pkg::WORD_W-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [4:0] dest_reg, [9:5] src1_reg, [14:10] src2_reg, [46:15] immediate,
  // [78:47] word_echo, [79] zero
  output logic [rvdec_pkg::TDATA_W-1:0] out_tdata,
  // [5:0] op_code, [8:6] exec_class, [9] is_branch_op, [10] is_load_op,
  // [11] is_store_op, [12] writes_dest
  output logic [rvdec_pkg::TUSER_W-1:0] out_tuser
);

  logic            s1_valid;
  logic            s1_ready;
  rvdec_pkg::s1_t  s1_data;
  logic            s2_valid;
  logic            s2_ready;
  rvdec_pkg::s2_t  s2_data;
  rvdec_pkg::res_t res;

  rvdec_fields u_fields (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_word   (in_tdata),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  rvdec_ops u_ops (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  rvdec_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res)
  );

  assign out_tdata = {1'b0, res.word, res.imm, res.rs2, res.rs1, res.rd};
  assign out_tuser = {res.wr, res.st, res.ld, res.br, res.cls, res.op};

`ifndef ASSERT_OFF
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res.op == rvdec_pkg::OP_INVALID) |->
      (res.cls == rvdec_pkg::CLS_TRAP) && (out_tdata[46:0] == '0) && (out_tuser[12:9] == '0))
    else $error("invalid decode carries nonzero fields");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0({res.br, res.ld, res.st}))
    else $error("more than one of branch, load and store set");

  a_wr_rd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.wr |-> (res.rd != '0))
    else $error("writes_dest set with zero destination");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready && s1_valid && s2_valid)
    else $error("input stalled while the pipeline has room");
`endif

endmodule

// ===== hdl/rvdec_fields.sv =====
// First decoder stage: registers the instruction word and its major opcode group.
// Depends on rvdec_pkg.
module rvdec_fields (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rvdec_pkg::WORD_W-1:0] in_word,
  output logic                       out_valid,
  input  logic                       out_ready,
  output rvdec_pkg::s1_t             out_data
);

  logic           valid_r;
  rvdec_pkg::s1_t data_r;
  rvdec_pkg::s1_t data_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    data_nxt.word = in_word;
    unique case (in_word[6:0])
      rvdec_pkg::OPC_LUI:    data_nxt.grp = rvdec_pkg::GRP_LUI;
      rvdec_pkg::OPC_AUIPC:  data_nxt.grp = rvdec_pkg::GRP_AUIPC;
      rvdec_pkg::OPC_JAL:    data_nxt.grp = rvdec_pkg::GRP_JAL;
      rvdec_pkg::OPC_JALR:   data_nxt.grp = rvdec_pkg::GRP_JALR;
      rvdec_pkg::OPC_BRANCH: data_nxt.grp = rvdec_pkg::GRP_BRANCH;
      rvdec_pkg::OPC_LOAD:   data_nxt.grp = rvdec_pkg::GRP_LOAD;
      rvdec_pkg::OPC_STORE:  data_nxt.grp = rvdec_pkg::GRP_STORE;
      rvdec_pkg::OPC_OPIMM:  data_nxt.grp = rvdec_pkg::GRP_OPIMM;
      rvdec_pkg::OPC_OP:     data_nxt.grp = rvdec_pkg::GRP_OP;
      rvdec_pkg::OPC_MISC:   data_nxt.grp = rvdec_pkg::GRP_MISC;
      rvdec_pkg::OPC_SYSTEM: data_nxt.grp = rvdec_pkg::GRP_SYSTEM;
      default:               data_nxt.grp = rvdec_pkg::GRP_BAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== hdl/rvdec_ops.sv =====
// Second decoder stage: resolves the operation, execution class, operand use and flags.
// Depends on rvdec_pkg.
module rvdec_ops (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rvdec_pkg::s1_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rvdec_pkg::s2_t out_data
);

  logic           valid_r;
  rvdec_pkg::s2_t data_r;
  rvdec_pkg::s2_t data_nxt;
  logic [2:0]     f3;
  logic [6:0]     f7;
  logic [11:0]    i12;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  assign f3  = in_data.word[14:12];
  assign f7  = in_data.word[31:25];
  assign i12 = in_data.word[31:20];

  always_comb begin
    data_nxt.word   = in_data.word;
    data_nxt.op     = rvdec_pkg::OP_INVALID;
    data_nxt.cls    = rvdec_pkg::CLS_TRAP;
    data_nxt.fmt    = rvdec_pkg::IMM_NONE;
    data_nxt.use_d  = 1'b0;
    data_nxt.use_s1 = 1'b0;
    data_nxt.use_s2 = 1'b0;
    data_nxt.br     = 1'b0;
    data_nxt.ld     = 1'b0;
    data_nxt.st     = 1'b0;
    data_nxt.wr     = 1'b0;
    unique case (in_data.grp)
      rvdec_pkg::GRP_LUI, rvdec_pkg::GRP_AUIPC: begin
        data_nxt.op    = (in_data.grp == rvdec_pkg::GRP_LUI) ? rvdec_pkg::OP_LUI
                                                             : rvdec_pkg::OP_AUIPC;
        data_nxt.cls   = rvdec_pkg::CLS_ALU;
        data_nxt.fmt   = rvdec_pkg::IMM_U;
        data_nxt.use_d = 1'b1;
        data_nxt.wr    = 1'b1;
      end
      rvdec_pkg::GRP_JAL: begin
        data_nxt.op    = rvdec_pkg::OP_JAL;
        data_nxt.cls   = rvdec_pkg::CLS_BRANCH;
        data_nxt.fmt   = rvdec_pkg::IMM_J;
        data_nxt.use_d = 1'b1;
        data_nxt.br    = 1'b1;
        data_nxt.wr    = 1'b1;
      end
      rvdec_pkg::GRP_JALR: begin
        data_nxt.op     = (f3 == 3'd0) ? rvdec_pkg::OP_JALR : rvdec_pkg::OP_INVALID;
        data_nxt.cls    = rvdec_pkg::CLS_BRANCH;
        data_nxt.fmt    = rvdec_pkg::IMM_I;
        data_nxt.use_d  = 1'b1;
        data_nxt.use_s1 = 1'b1;
        data_nxt.br     = 1'b1;
        data_nxt.wr     = 1'b1;
      end
      rvdec_pkg::GRP_BRANCH: begin
        unique case (f3)
          3'd0:    data_nxt.op = rvdec_pkg::OP_BEQ;
          3'd1:    data_nxt.op = rvdec_pkg::OP_BNE;
          3'd4:    data_nxt.op = rvdec_pkg::OP_BLT;
          3'd5:    data_nxt.op = rvdec_pkg::OP_BGE;
          3'd6:    data_nxt.op = rvdec_pkg::OP_BLTU;
          3'd7:    data_nxt.op = rvdec_pkg::OP_BGEU;
          default: data_nxt.op = rvdec_pkg::OP_INVALID;
        endcase
        data_nxt.cls    = rvdec_pkg::CLS_BRANCH;
        data_nxt.fmt    = rvdec_pkg::IMM_B;
        data_nxt.use_s1 = 1'b1;
        data_nxt.use_s2 = 1'b1;
        data_nxt.br     = 1'b1;
      end
      rvdec_pkg::GRP_LOAD: begin
        unique case (f3)
          3'd0:    data_nxt.op = rvdec_pkg::OP_LB;
          3'd1:    data_nxt.op = rvdec_pkg::OP_LH;
          3'd2:    data_nxt.op = rvdec_pkg::OP_LW;
          3'd4:    data_nxt.op = rvdec_pkg::OP_LBU;
          3'd5:    data_nxt.op = rvdec_pkg::OP_LHU;
          default: data_nxt.op = rvdec_pkg::OP_INVALID;
        endcase
        data_nxt.cls    = rvdec_pkg::CLS_LOAD;
        data_nxt.fmt    = rvdec_pkg::IMM_I;
        data_nxt.use_d  = 1'b1;
        data_nxt.use_s1 = 1'b1;
        data_nxt.ld     = 1'b1;
        data_nxt.wr     = 1'b1;
      end
      rvdec_pkg::GRP_STORE: begin
        unique case (f3)
          3'd0:    data_nxt.op = rvdec_pkg::OP_SB;
          3'd1:    data_nxt.op = rvdec_pkg::OP_SH;
          3'd2:    data_nxt.op = rvdec_pkg::OP_SW;
          default: data_nxt.op = rvdec_pkg::OP_INVALID;
        endcase
        data_nxt.cls    = rvdec_pkg::CLS_STORE;
        data_nxt.fmt    = rvdec_pkg::IMM_S;
        data_nxt.use_s1 = 1'b1;
        data_nxt.use_s2 = 1'b1;
        data_nxt.st     = 1'b1;
      end
      rvdec_pkg::GRP_OPIMM: begin
        data_nxt.cls    = rvdec_pkg::CLS_ALU;
        data_nxt.fmt    = rvdec_pkg::IMM_I;
        data_nxt.use_d  = 1'b1;
        data_nxt.use_s1 = 1'b1;
        data_nxt.wr     = 1'b1;
        unique case (f3)
          3'd0: data_nxt.op = rvdec_pkg::OP_ADD;
          3'd1: begin
            data_nxt.op  = (f7 == rvdec_pkg::F7_BASE) ? rvdec_pkg::OP_SLL
                                                      : rvdec_pkg::OP_INVALID;
            data_nxt.fmt = rvdec_pkg::IMM_SH;
          end
          3'd2: data_nxt.op = rvdec_pkg::OP_SLT;
          3'd3: data_nxt.op = rvdec_pkg::OP_SLTU;
          3'd4: data_nxt.op = rvdec_pkg::OP_XOR;
          3'd5: begin
            if ((f7 & rvdec_pkg::SRX_MASK) != 7'd0) begin
              data_nxt.op = rvdec_pkg::OP_INVALID;
            end else if (f7[5]) begin
              data_nxt.op = rvdec_pkg::OP_SRA;
            end else begin
              data_nxt.op = rvdec_pkg::OP_SRL;
            end
            data_nxt.fmt = rvdec_pkg::IMM_SH;
          end
          3'd6: data_nxt.op = rvdec_pkg::OP_OR;
          3'd7: data_nxt.op = rvdec_pkg::OP_AND;
          default: data_nxt.op = rvdec_pkg::OP_INVALID;
        endcase
      end
      rvdec_pkg::GRP_OP: begin
        data_nxt.cls    = rvdec_pkg::CLS_ALU;
        data_nxt.use_d  = 1'b1;
        data_nxt.use_s1 = 1'b1;
        data_nxt.use_s2 = 1'b1;
        data_nxt.wr     = 1'b1;
        priority if (f7 == rvdec_pkg::F7_MULDIV) begin
          data_nxt.cls = f3[2] ? rvdec_pkg::CLS_DIV : rvdec_pkg::CLS_MUL;
          unique case (f3)
            3'd0:    data_nxt.op = rvdec_pkg::OP_MUL;
            3'd1:    data_nxt.op = rvdec_pkg::OP_MULH;
            3'd2:    data_nxt.op = rvdec_pkg::OP_MULHSU;
            3'd3:    data_nxt.op = rvdec_pkg::OP_MULHU;
            3'd4:    data_nxt.op = rvdec_pkg::OP_DIV;
            3'd5:    data_nxt.op = rvdec_pkg::OP_DIVU;
            3'd6:    data_nxt.op = rvdec_pkg::OP_REM;
            3'd7:    data_nxt.op = rvdec_pkg::OP_REMU;
            default: data_nxt.op = rvdec_pkg::OP_INVALID;
          endcase
        end else if (f7 == rvdec_pkg::F7_BASE) begin
          unique case (f3)
            3'd0:    data_nxt.op = rvdec_pkg::OP_ADD;
            3'd1:    data_nxt.op = rvdec_pkg::OP_SLL;
            3'd2:    data_nxt.op = rvdec_pkg::OP_SLT;
            3'd3:    data_nxt.op = rvdec_pkg::OP_SLTU;
            3'd4:    data_nxt.op = rvdec_pkg::OP_XOR;
            3'd5:    data_nxt.op = rvdec_pkg::OP_SRL;
            3'd6:    data_nxt.op = rvdec_pkg::OP_OR;
            3'd7:    data_nxt.op = rvdec_pkg::OP_AND;
            default: data_nxt.op = rvdec_pkg::OP_INVALID;
          endcase
        end else if (f7 == rvdec_pkg::F7_ALT) begin
          priority if (f3 == 3'd0) begin
            data_nxt.op = rvdec_pkg::OP_SUB;
          end else if (f3 == 3'd5) begin
            data_nxt.op = rvdec_pkg::OP_SRA;
          end else begin
            data_nxt.op = rvdec_pkg::OP_INVALID;
          end
        end else begin
          data_nxt.op = rvdec_pkg::OP_INVALID;
        end
      end
      rvdec_pkg::GRP_MISC: begin
        data_nxt.cls = rvdec_pkg::CLS_NOP;
        priority if (f3 == 3'd0) begin
          data_nxt.op = rvdec_pkg::OP_FENCE;
        end else if (f3 == 3'd1) begin
          data_nxt.op = rvdec_pkg::OP_FENCE_I;
        end else begin
          data_nxt.op = rvdec_pkg::OP_INVALID;
        end
      end
      rvdec_pkg::GRP_SYSTEM: begin
        priority if (f3 == 3'd0 && i12 == 12'd0) begin
          data_nxt.op = rvdec_pkg::OP_ECALL;
        end else if (f3 == 3'd0 && i12 == 12'd1) begin
          data_nxt.op = rvdec_pkg::OP_EBREAK;
        end else begin
          data_nxt.op = rvdec_pkg::OP_INVALID;
        end
      end
      default: data_nxt.op = rvdec_pkg::OP_INVALID;
    endcase

    if (data_nxt.op == rvdec_pkg::OP_INVALID) begin
      data_nxt.cls    = rvdec_pkg::CLS_TRAP;
      data_nxt.fmt    = rvdec_pkg::IMM_NONE;
      data_nxt.use_d  = 1'b0;
      data_nxt.use_s1 = 1'b0;
      data_nxt.use_s2 = 1'b0;
      data_nxt.br     = 1'b0;
      data_nxt.ld     = 1'b0;
      data_nxt.st     = 1'b0;
      data_nxt.wr     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== hdl/rvdec_pack.sv =====
// Third decoder stage: builds the immediate and register fields into the result register.
// Depends on rvdec_pkg.
module rvdec_pack (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rvdec_pkg::s2_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rvdec_pkg::res_t out_data
);

  logic                        valid_r;
  rvdec_pkg::res_t             data_r;
  rvdec_pkg::res_t             data_nxt;
  logic [rvdec_pkg::WORD_W-1:0] w;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;
  assign w         = in_data.word;

  always_comb begin
    data_nxt.word = w;
    data_nxt.op   = in_data.op;
    data_nxt.cls  = in_data.cls;
    data_nxt.br   = in_data.br;
    data_nxt.ld   = in_data.ld;
    data_nxt.st   = in_data.st;
    data_nxt.rd   = in_data.use_d  ? w[11:7]  : '0;
    data_nxt.rs1  = in_data.use_s1 ? w[19:15] : '0;
    data_nxt.rs2  = in_data.use_s2 ? w[24:20] : '0;
    data_nxt.wr   = in_data.wr && in_data.use_d && (w[11:7] != '0);
    unique case (in_data.fmt)
      rvdec_pkg::IMM_I:  data_nxt.imm = {{20{w[31]}}, w[31:20]};
      rvdec_pkg::IMM_S:  data_nxt.imm = {{20{w[31]}}, w[31:25], w[11:7]};
      rvdec_pkg::IMM_B:  data_nxt.imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
      rvdec_pkg::IMM_U:  data_nxt.imm = {w[31:12], 12'd0};
      rvdec_pkg::IMM_J:  data_nxt.imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
      rvdec_pkg::IMM_SH: data_nxt.imm = {27'd0, w[24:20]};
      default:           data_nxt.imm = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== bench/rv32im_decoder_checker.sv =====
// Checker for the RV32IM instruction decoder: watches both stream channels,
// predicts each decoded result from the accepted word and compares it field by field.
// Depends on rvdec_pkg for the opcode constants and the operation and class enums.
module rv32im_decoder_checker
  import rvdec_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [WORD_W-1:0]  in_tdata,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [TDATA_W-1:0] out_tdata,
  input  logic [TUSER_W-1:0] out_tuser,
  output int                 fail_count,
  output int                 decodes_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    op_t               op;
    cls_t              cls;
    logic [REG_W-1:0]  rd;
    logic [REG_W-1:0]  rs1;
    logic [REG_W-1:0]  rs2;
    logic [WORD_W-1:0] imm;
    logic              br;
    logic              ld;
    logic              st;
    logic              wr;
    logic [WORD_W-1:0] word;
  } decoded_t;

  decoded_t expected_decodes[$];

  function automatic decoded_t decode_rv32im(input logic [WORD_W-1:0] w);
    decoded_t   r;
    logic [6:0] opc;
    logic [6:0] f7;
    logic [2:0] f3;
    logic [WORD_W-1:0] imm_i;
    logic       legal;
    r     = '0;
    opc   = w[6:0];
    f3    = w[14:12];
    f7    = w[31:25];
    imm_i = {{20{w[31]}}, w[31:20]};
    legal = 1'b1;
    r.op  = OP_INVALID;
    r.cls = CLS_TRAP;
    case (opc)
      OPC_LUI, OPC_AUIPC: begin
        r.op  = (opc == OPC_LUI) ? OP_LUI : OP_AUIPC;
        r.cls = CLS_ALU;
        r.imm = {w[31:12], 12'b0};
        r.rd  = w[11:7];
        r.wr  = 1'b1;
      end
      OPC_JAL: begin
        r.op  = OP_JAL;
        r.cls = CLS_BRANCH;
        r.rd  = w[11:7];
        r.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        r.br  = 1'b1;
        r.wr  = 1'b1;
      end
      OPC_JALR: begin
        legal = (f3 == 3'd0);
        r.op  = OP_JALR;
        r.cls = CLS_BRANCH;
        r.rd  = w[11:7];
        r.rs1 = w[19:15];
        r.imm = imm_i;
        r.br  = 1'b1;
        r.wr  = 1'b1;
      end
      OPC_BRANCH: begin
        case (f3)
          3'd0: r.op = OP_BEQ;
          3'd1: r.op = OP_BNE;
          3'd4: r.op = OP_BLT;
          3'd5: r.op = OP_BGE;
          3'd6: r.op = OP_BLTU;
          3'd7: r.op = OP_BGEU;
          default: r.op = OP_INVALID;
        endcase
        r.cls = CLS_BRANCH;
        r.rs1 = w[19:15];
        r.rs2 = w[24:20];
        r.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        r.br  = 1'b1;
      end
      OPC_LOAD: begin
        case (f3)
          3'd0: r.op = OP_LB;
          3'd1: r.op = OP_LH;
          3'd2: r.op = OP_LW;
          3'd4: r.op = OP_LBU;
          3'd5: r.op = OP_LHU;
          default: r.op = OP_INVALID;
        endcase
        r.cls = CLS_LOAD;
        r.rd  = w[11:7];
        r.rs1 = w[19:15];
        r.imm = imm_i;
        r.ld  = 1'b1;
        r.wr  = 1'b1;
      end
      OPC_STORE: begin
        case (f3)
          3'd0: r.op = OP_SB;
          3'd1: r.op = OP_SH;
          3'd2: r.op = OP_SW;
          default: r.op = OP_INVALID;
        endcase
        r.cls = CLS_STORE;
        r.rs1 = w[19:15];
        r.rs2 = w[24:20];
        r.imm = {{20{w[31]}}, w[31:25], w[11:7]};
        r.st  = 1'b1;
      end
      OPC_OPIMM: begin
        r.cls = CLS_ALU;
        r.rd  = w[11:7];
        r.rs1 = w[19:15];
        r.imm = imm_i;
        r.wr  = 1'b1;
        case (f3)
          3'd0: r.op = OP_ADD;
          3'd1: begin
            r.op  = (f7 == F7_BASE) ? OP_SLL : OP_INVALID;
            r.imm = {27'b0, w[24:20]};
          end
          3'd2: r.op = OP_SLT;
          3'd3: r.op = OP_SLTU;
          3'd4: r.op = OP_XOR;
          3'd5: begin
            if ((f7 & SRX_MASK) != 7'd0) begin
              r.op = OP_INVALID;
            end else begin
              r.op = f7[5] ? OP_SRA : OP_SRL;
            end
            r.imm = {27'b0, w[24:20]};
          end
          3'd6: r.op = OP_OR;
          default: r.op = OP_AND;
        endcase
      end
      OPC_OP: begin
        r.cls = CLS_ALU;
        r.rd  = w[11:7];
        r.rs1 = w[19:15];
        r.rs2 = w[24:20];
        r.wr  = 1'b1;
        if (f7 == F7_MULDIV) begin
          r.op  = op_t'(OP_MUL + 6'(f3));
          r.cls = (f3 < 3'd4) ? CLS_MUL : CLS_DIV;
        end else if (f7 == F7_BASE) begin
          case (f3)
            3'd0: r.op = OP_ADD;
            3'd1: r.op = OP_SLL;
            3'd2: r.op = OP_SLT;
            3'd3: r.op = OP_SLTU;
            3'd4: r.op = OP_XOR;
            3'd5: r.op = OP_SRL;
            3'd6: r.op = OP_OR;
            default: r.op = OP_AND;
          endcase
        end else if (f7 == F7_ALT) begin
          r.op = (f3 == 3'd0) ? OP_SUB : ((f3 == 3'd5) ? OP_SRA : OP_INVALID);
        end else begin
          r.op = OP_INVALID;
        end
      end
      OPC_MISC: begin
        r.cls = CLS_NOP;
        r.op  = (f3 == 3'd0) ? OP_FENCE : ((f3 == 3'd1) ? OP_FENCE_I : OP_INVALID);
      end
      OPC_SYSTEM: begin
        r.cls = CLS_TRAP;
        if (f3 == 3'd0 && w[31:20] == 12'd0) begin
          r.op = OP_ECALL;
        end else if (f3 == 3'd0 && w[31:20] == 12'd1) begin
          r.op = OP_EBREAK;
        end
      end
      default: r.op = OP_INVALID;
    endcase
    if (r.op == OP_INVALID) legal = 1'b0;
    if (!legal) begin
      r     = '0;
      r.op  = OP_INVALID;
      r.cls = CLS_TRAP;
    end else begin
      r.wr = r.wr && (r.rd != '0);
    end
    r.word = w;
    return r;
  endfunction

  function automatic string show(input decoded_t d);
    return $sformatf("op=%0d cls=%0d rd=%0d rs1=%0d rs2=%0d imm=%h br=%b ld=%b st=%b wr=%b word=%h",
                     d.op, d.cls, d.rd, d.rs1, d.rs2, d.imm, d.br, d.ld, d.st, d.wr, d.word);
  endfunction

  always @(posedge clk) begin : check_beats
    decoded_t want;
    decoded_t got;
    logic     differs;
    if (!rst_n) begin
      expected_decodes.delete();
      fail_count = 0;
      decodes_pending <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.rd   = out_tdata[4:0];
        got.rs1  = out_tdata[9:5];
        got.rs2  = out_tdata[14:10];
        got.imm  = out_tdata[46:15];
        got.word = out_tdata[78:47];
        got.op   = op_t'(out_tuser[5:0]);
        got.cls  = cls_t'(out_tuser[8:6]);
        got.br   = out_tuser[9];
        got.ld   = out_tuser[10];
        got.st   = out_tuser[11];
        got.wr   = out_tuser[12];
        if (expected_decodes.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat: %s", show(got));
        end else begin
          want = expected_decodes.pop_front();
          differs = (got.op !== want.op) || (got.cls !== want.cls) ||
                    (got.rd !== want.rd) || (got.rs1 !== want.rs1) ||
                    (got.rs2 !== want.rs2) || (got.imm !== want.imm) ||
                    (got.br !== want.br) || (got.ld !== want.ld) ||
                    (got.st !== want.st) || (got.wr !== want.wr) ||
                    (got.word !== want.word);
          if (differs) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch expected: %s", show(want));
              $display("         actual:   %s", show(got));
            end
          end
        end
      end
      if (in_tvalid && in_tready) expected_decodes.push_back(decode_rv32im(in_tdata));
      decodes_pending <= expected_decodes.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
// Top of the decoder testbench: clock, reset, instruction stimulus and the verdict.
// Depends on rvdec_pkg, the rv32im_instruction_decoder block and rv32im_decoder_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rvdec_pkg::*;

  localparam int WORDS_PER_PHASE = 230;
  localparam logic [6:0] LEGAL_OPCODES [11] = '{
    OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR, OPC_BRANCH, OPC_LOAD,
    OPC_STORE, OPC_OPIMM, OPC_OP, OPC_MISC, OPC_SYSTEM
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [WORD_W-1:0]  in_tdata = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic [TUSER_W-1:0] out_tuser;
  int                 fail_count;
  int                 decodes_pending;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;

  rv32im_instruction_decoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  rv32im_decoder_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .fail_count      (fail_count),
    .decodes_pending (decodes_pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [WORD_W-1:0] enc(input logic [6:0] opc, input logic [2:0] f3,
                                            input logic [6:0] f7, input logic [4:0] rd,
                                            input logic [4:0] rs1, input logic [4:0] rs2);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic [WORD_W-1:0] random_instr();
    logic [WORD_W-1:0] w;
    w = $urandom;
    if ($urandom_range(99) < 12) return w;
    w[6:0] = LEGAL_OPCODES[$urandom_range(10)];
    case (w[6:0])
      OPC_OP, OPC_OPIMM: begin
        case ($urandom_range(7))
          0, 1, 2: w[31:25] = F7_BASE;
          3, 4:    w[31:25] = F7_ALT;
          5, 6:    w[31:25] = F7_MULDIV;
          default: ;
        endcase
      end
      OPC_JALR: if ($urandom_range(3) != 0) w[14:12] = 3'd0;
      OPC_MISC: if ($urandom_range(4) != 0) w[14:12] = 3'($urandom_range(2));
      OPC_SYSTEM: begin
        if ($urandom_range(4) != 0) begin
          w[14:12] = 3'd0;
          w[31:20] = 12'($urandom_range(1));
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_word(input logic [WORD_W-1:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(enc(OPC_LUI, 3'd7, 7'h7F, 5'd0, 5'd31, 5'd31));
    send_word(enc(OPC_AUIPC, 3'd0, 7'h40, 5'd31, 5'd0, 5'd0));
    send_word(enc(OPC_JAL, 3'd7, 7'h7F, 5'd1, 5'd31, 5'd31));
    send_word(enc(OPC_JAL, 3'd7, 7'h3F, 5'd0, 5'd31, 5'd31));
    send_word(enc(OPC_JALR, 3'd0, 7'h40, 5'd0, 5'd31, 5'd0));
    send_word(enc(OPC_JALR, 3'd1, 7'h00, 5'd5, 5'd6, 5'd7));
    send_word(enc(OPC_BRANCH, 3'd0, 7'h7F, 5'd31, 5'd1, 5'd2));
    send_word(enc(OPC_BRANCH, 3'd2, 7'h00, 5'd4, 5'd1, 5'd2));
    send_word(enc(OPC_BRANCH, 3'd7, 7'h3F, 5'd30, 5'd31, 5'd31));
    send_word(enc(OPC_LOAD, 3'd4, 7'h40, 5'd0, 5'd31, 5'd0));
    send_word(enc(OPC_LOAD, 3'd3, 7'h00, 5'd3, 5'd4, 5'd0));
    send_word(enc(OPC_STORE, 3'd2, 7'h7F, 5'd31, 5'd31, 5'd31));
    send_word(enc(OPC_STORE, 3'd3, 7'h00, 5'd1, 5'd2, 5'd3));
    send_word(enc(OPC_OPIMM, 3'd0, 7'h7F, 5'd31, 5'd31, 5'd31));
    send_word(enc(OPC_OPIMM, 3'd1, F7_BASE, 5'd5, 5'd6, 5'd31));
    send_word(enc(OPC_OPIMM, 3'd1, F7_ALT, 5'd5, 5'd6, 5'd31));
    send_word(enc(OPC_OPIMM, 3'd5, F7_BASE, 5'd7, 5'd8, 5'd0));
    send_word(enc(OPC_OPIMM, 3'd5, F7_ALT, 5'd9, 5'd10, 5'd31));
    send_word(enc(OPC_OPIMM, 3'd5, 7'h40, 5'd9, 5'd10, 5'd1));
    send_word(enc(OPC_OP, 3'd0, F7_ALT, 5'd11, 5'd12, 5'd13));
    send_word(enc(OPC_OP, 3'd3, F7_ALT, 5'd11, 5'd12, 5'd13));
    send_word(enc(OPC_OP, 3'd7, F7_MULDIV, 5'd31, 5'd31, 5'd31));
    send_word(enc(OPC_OP, 3'd0, 7'h02, 5'd1, 5'd1, 5'd1));
    send_word(enc(OPC_MISC, 3'd0, 7'h7F, 5'd31, 5'd31, 5'd31));
    send_word(enc(OPC_MISC, 3'd1, 7'h00, 5'd0, 5'd0, 5'd0));
    send_word(enc(OPC_MISC, 3'd2, 7'h00, 5'd0, 5'd0, 5'd0));
    send_word(enc(OPC_SYSTEM, 3'd0, 7'h00, 5'd31, 5'd31, 5'd0));
    send_word(enc(OPC_SYSTEM, 3'd0, 7'h00, 5'd0, 5'd0, 5'd1));
    send_word(enc(OPC_SYSTEM, 3'd0, 7'h00, 5'd0, 5'd0, 5'd2));
    send_word(enc(OPC_SYSTEM, 3'd1, 7'h00, 5'd0, 5'd0, 5'd0));

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      repeat (WORDS_PER_PHASE) send_word(random_instr());
      // The sender holds off until every decoded beat has come back.
      in_tvalid <= 1'b0;
      do @(negedge clk); while (decodes_pending != 0);
      @(posedge clk);
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && decodes_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
